// ----- hw/rtl/cmlt_pkg.sv -----
package cmlt_pkg;

	localparam int OP_W  = 3;
	localparam int IDX_W = 6;
	localparam int LBL_W = 6;
	localparam int CNT_W = 7;
	localparam int ST_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 3'd0,
		OP_MERGE = 3'd1,
		OP_QUERY = 3'd2,
		OP_LIST  = 3'd3,
		OP_DUMP  = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_SAME  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEL_A   = 2'd0,
		SEL_B   = 2'd1,
		SEL_IDX = 2'd2
	} rd_sel_t;

	typedef enum logic [2:0] {
		USE_NONE  = 3'd0,
		USE_LA    = 3'd1,
		USE_LB    = 3'd2,
		USE_MERGE = 3'd3,
		USE_LIST  = 3'd4,
		USE_DUMP  = 3'd5
	} rd_use_t;

	typedef enum logic [2:0] {
		EMIT_NONE  = 3'd0,
		EMIT_CLEAR = 3'd1,
		EMIT_SAME  = 3'd2,
		EMIT_RANGE = 3'd3,
		EMIT_MERGE = 3'd4,
		EMIT_QUERY = 3'd5,
		EMIT_LIST  = 3'd6
	} emit_t;

	typedef struct packed {
		logic    load;
		logic    clear;
		rd_sel_t rd_sel;
		rd_use_t rd_use;
		logic    idx_clr;
		logic    idx_inc;
		logic    pend_clr;
		logic    dec_groups;
		emit_t   emit;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            same_idx;
		logic            a_oor;
		logic            b_oor;
		logic            la_eq_lb;
		logic            walk_last;
	} sts_t;

endpackage

// ----- hw/rtl/cmlt_datapath.sv -----
module cmlt_datapath
	import cmlt_pkg::*;
#(
	parameter int MAX_CLUSTERS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [OP_W-1:0]  op,
	input  logic [IDX_W-1:0] first_index,
	input  logic [IDX_W-1:0] second_index,
	input  logic             cluster_count_we,
	input  logic [CNT_W-1:0] cluster_count,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic             result_strobe,
	output logic [ST_W-1:0]  status,
	output logic             merged,
	output logic [IDX_W-1:0] member_index,
	output logic [LBL_W-1:0] group_label,
	output logic [CNT_W-1:0] group_count,
	output logic             last
);

	localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CLUSTERS);

	logic [LBL_W-1:0]        labels_q [MAX_CLUSTERS];
	logic [MAX_CLUSTERS-1:0] written_q;

	logic [OP_W-1:0]  op_q;
	logic [IDX_W-1:0] a_q, b_q, idx_q, pend_q;
	logic             pend_vld_q;
	logic [LBL_W-1:0] la_q, lb_q;
	logic [CNT_W-1:0] cfg_q, in_use_q, groups_q;

	logic [IDX_W-1:0] rd_addr;
	logic [LBL_W-1:0] rd_data_s1;
	logic [IDX_W-1:0] rd_addr_s1;
	logic             rd_written_s1;
	rd_use_t          rd_use_s1;
	logic [LBL_W-1:0] rd_label;

	logic [CNT_W-1:0] n_sat, groups_d;
	logic [LBL_W-1:0] lo, hi, wr_data;
	logic             wr_en, list_hit, dump_hit;

	logic             e_v, e_merged, e_last;
	status_t          e_status;
	logic [IDX_W-1:0] e_member;
	logic [LBL_W-1:0] e_label;

	always_comb begin
		rd_addr = a_q;
		unique case (cmd.rd_sel)
			SEL_A:   rd_addr = a_q;
			SEL_B:   rd_addr = b_q;
			SEL_IDX: rd_addr = idx_q;
			default: rd_addr = a_q;
		endcase
	end

	assign rd_label = rd_written_s1 ? rd_data_s1 : rd_addr_s1;
	assign lo       = (la_q < lb_q) ? la_q : lb_q;
	assign hi       = (la_q < lb_q) ? lb_q : la_q;
	assign wr_en    = (rd_use_s1 == USE_MERGE);
	assign list_hit = (rd_use_s1 == USE_LIST) && (rd_label == la_q);
	assign dump_hit = (rd_use_s1 == USE_DUMP);

	always_comb begin
		if (rd_label == lo || rd_label == hi) begin
			wr_data = lo;
		end else if (rd_label > hi) begin
			wr_data = rd_label - LBL_W'(1);
		end else begin
			wr_data = rd_label;
		end
	end

	always_comb begin
		if (cfg_q == '0) begin
			n_sat = CNT_W'(1);
		end else if (cfg_q > MAX_CNT) begin
			n_sat = MAX_CNT;
		end else begin
			n_sat = cfg_q;
		end
	end

	always_comb begin
		groups_d = groups_q;
		if (cmd.clear) begin
			groups_d = n_sat;
		end else if (cmd.dec_groups && groups_q != '0) begin
			groups_d = groups_q - CNT_W'(1);
		end
	end

	assign sts.op        = op_q;
	assign sts.same_idx  = (a_q == b_q);
	assign sts.a_oor     = ({1'b0, a_q} >= in_use_q);
	assign sts.b_oor     = ({1'b0, b_q} >= in_use_q);
	assign sts.la_eq_lb  = (la_q == lb_q);
	assign sts.walk_last = ({1'b0, idx_q} == (in_use_q - CNT_W'(1)));

	always_comb begin
		e_v      = 1'b0;
		e_status = ST_OK;
		e_merged = 1'b0;
		e_member = '0;
		e_label  = '0;
		e_last   = 1'b1;
		unique case (cmd.emit)
			EMIT_CLEAR: begin
				e_v = 1'b1;
			end
			EMIT_SAME: begin
				e_v      = 1'b1;
				e_status = ST_SAME;
			end
			EMIT_RANGE: begin
				e_v      = 1'b1;
				e_status = ST_RANGE;
			end
			EMIT_MERGE: begin
				e_v      = 1'b1;
				e_merged = 1'b1;
				e_label  = lo;
			end
			EMIT_QUERY: begin
				e_v      = 1'b1;
				e_merged = (la_q == lb_q);
				e_label  = la_q;
			end
			EMIT_LIST: begin
				e_v      = 1'b1;
				e_member = pend_q;
				e_label  = la_q;
			end
			default: begin
				if (dump_hit) begin
					e_v      = 1'b1;
					e_member = rd_addr_s1;
					e_label  = rd_label;
					e_last   = ({1'b0, rd_addr_s1} == (in_use_q - CNT_W'(1)));
				end else if (list_hit && pend_vld_q) begin
					e_v      = 1'b1;
					e_member = pend_q;
					e_label  = la_q;
					e_last   = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_use != USE_NONE) begin
			rd_data_s1 <= labels_q[rd_addr[AW-1:0]];
		end
		if (wr_en) begin
			labels_q[rd_addr_s1[AW-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_addr;
		if (cmd.load) begin
			op_q <= op;
			a_q  <= first_index;
			b_q  <= second_index;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (rd_use_s1 == USE_LA) begin
			la_q <= rd_label;
		end
		if (rd_use_s1 == USE_LB) begin
			lb_q <= rd_label;
		end
		if (list_hit) begin
			pend_q <= rd_addr_s1;
		end
		if (e_v) begin
			status       <= e_status;
			merged       <= e_merged;
			member_index <= e_member;
			group_label  <= e_label;
			group_count  <= groups_d;
			last         <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q     <= '0;
			rd_written_s1 <= 1'b0;
			rd_use_s1     <= USE_NONE;
			pend_vld_q    <= 1'b0;
			cfg_q         <= MAX_CNT;
			in_use_q      <= MAX_CNT;
			groups_q      <= MAX_CNT;
			result_strobe <= 1'b0;
		end else begin
			rd_written_s1 <= written_q[rd_addr[AW-1:0]];
			rd_use_s1     <= cmd.rd_use;
			result_strobe <= e_v;
			groups_q      <= groups_d;
			if (cluster_count_we) begin
				cfg_q <= cluster_count;
			end
			if (cmd.clear) begin
				written_q <= '0;
				in_use_q  <= n_sat;
			end else if (wr_en) begin
				written_q[rd_addr_s1[AW-1:0]] <= 1'b1;
			end
			if (cmd.pend_clr) begin
				pend_vld_q <= 1'b0;
			end else if (list_hit) begin
				pend_vld_q <= 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/cmlt_ctrl.sv -----
module cmlt_ctrl
	import cmlt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output logic busy,
	output cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_CHECK  = 9'b000000010,
		S_RDB    = 9'b000000100,
		S_WAITB  = 9'b000001000,
		S_DECIDE = 9'b000010000,
		S_WAITA  = 9'b000100000,
		S_WALK   = 9'b001000000,
		S_FLUSH  = 9'b010000000,
		S_FIN    = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd.load       = 1'b0;
		cmd.clear      = 1'b0;
		cmd.rd_sel     = SEL_A;
		cmd.rd_use     = USE_NONE;
		cmd.idx_clr    = 1'b0;
		cmd.idx_inc    = 1'b0;
		cmd.pend_clr   = 1'b0;
		cmd.dec_groups = 1'b0;
		cmd.emit       = EMIT_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_IDLE;
				case (sts.op)
					OP_CLEAR: begin
						cmd.clear = 1'b1;
						cmd.emit  = EMIT_CLEAR;
					end
					OP_MERGE: begin
						if (sts.same_idx) begin
							cmd.emit = EMIT_SAME;
						end else if (sts.a_oor || sts.b_oor) begin
							cmd.emit = EMIT_RANGE;
						end else begin
							cmd.rd_use = USE_LA;
							state_d    = S_RDB;
						end
					end
					OP_QUERY: begin
						if (sts.a_oor || sts.b_oor) begin
							cmd.emit = EMIT_RANGE;
						end else begin
							cmd.rd_use = USE_LA;
							state_d    = S_RDB;
						end
					end
					OP_LIST: begin
						if (sts.a_oor) begin
							cmd.emit = EMIT_RANGE;
						end else begin
							cmd.rd_use = USE_LA;
							state_d    = S_WAITA;
						end
					end
					OP_DUMP: begin
						cmd.idx_clr = 1'b1;
						state_d     = S_WALK;
					end
					default: begin
						cmd.emit = EMIT_RANGE;
					end
				endcase
			end
			S_RDB: begin
				cmd.rd_sel = SEL_B;
				cmd.rd_use = USE_LB;
				state_d    = S_WAITB;
			end
			S_WAITB: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.op == OP_QUERY) begin
					cmd.emit = EMIT_QUERY;
					state_d  = S_IDLE;
				end else if (sts.la_eq_lb) begin
					cmd.emit = EMIT_MERGE;
					state_d  = S_IDLE;
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = S_WALK;
				end
			end
			S_WAITA: begin
				cmd.idx_clr  = 1'b1;
				cmd.pend_clr = 1'b1;
				state_d      = S_WALK;
			end
			S_WALK: begin
				cmd.rd_sel  = SEL_IDX;
				cmd.idx_inc = 1'b1;
				if (sts.op == OP_MERGE) begin
					cmd.rd_use = USE_MERGE;
				end else if (sts.op == OP_LIST) begin
					cmd.rd_use = USE_LIST;
				end else begin
					cmd.rd_use = USE_DUMP;
				end
				if (sts.walk_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.op == OP_MERGE) begin
					cmd.dec_groups = 1'b1;
					cmd.emit       = EMIT_MERGE;
				end else if (sts.op == OP_LIST) begin
					cmd.emit = EMIT_LIST;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/cluster_merge_label_table.sv -----
// Channel   Handshake                    Payload
// --------  ---------------------------  ----------------------------------------------
// command   start & !busy                op, first_index, second_index
// result    result_strobe (one cycle)    status, merged, member_index, group_label,
//                                        group_count, last
// config    cluster_count_we             cluster_count
//
// busy is held for each item; n = clusters in use. Dump, listing and merge walk
// all n entries; clear, errors, pair queries and a merge of two clusters already in one group do not. The label
// memory has one read port and is walked one entry per cycle.
// Reset is asynchronous; every label reads as its own index after reset or clear
// through per-entry written flags, so there is no clearing pass.
// Results leave one per cycle at most; the receiver cannot stall them.
module cluster_merge_label_table
	import cmlt_pkg::*;
#(
	parameter int MAX_CLUSTERS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [OP_W-1:0]  op,
	input  logic [IDX_W-1:0] first_index,
	input  logic [IDX_W-1:0] second_index,
	input  logic             cluster_count_we,
	input  logic [CNT_W-1:0] cluster_count,
	output logic             result_strobe,
	output logic [ST_W-1:0]  status,
	output logic             merged,
	output logic [IDX_W-1:0] member_index,
	output logic [LBL_W-1:0] group_label,
	output logic [CNT_W-1:0] group_count,
	output logic             last
);

	cmd_t cmd;
	sts_t sts;

	cmlt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	cmlt_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.first_index      (first_index),
		.second_index     (second_index),
		.cluster_count_we (cluster_count_we),
		.cluster_count    (cluster_count),
		.cmd              (cmd),
		.sts              (sts),
		.result_strobe    (result_strobe),
		.status           (status),
		.merged           (merged),
		.member_index     (member_index),
		.group_label      (group_label),
		.group_count      (group_count),
		.last             (last)
	);

endmodule
